@@ rtl/sbtp_pkg.sv @@
// Package for the seven-bit text packer: transaction types, header constants
// and input mode codes. No dependencies.
`default_nettype none

package sbtp_pkg;

    // Input mode codes.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // Packing constants.
    localparam int unsigned DATA_BITS   = 7;
    localparam int unsigned MAX_RESULTS = 6;
    localparam logic [7:0]  MARK_BIT    = 8'h80;
    localparam logic [7:0]  TERMINATOR  = 8'h00;

    // Message header, first byte at index 0.
    localparam logic [3:0][7:0] HEADER = {8'h42, 8'h44, 8'h0a, 8'h0d};

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } msg_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } txt_item_t;

    // Characters produced by one input transaction, in emission order.
    typedef struct packed {
        logic [2:0]                   count;
        logic [MAX_RESULTS-1:0][7:0]  chars;
    } char_list_t;

endpackage

`default_nettype wire

@@ rtl/sbtp_expand.sv @@
// Packing state and the combinational expansion of one input transaction into
// its list of output characters. Depends on sbtp_pkg.
`default_nettype none

module sbtp_expand (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sbtp_pkg::msg_item_t   item,
    input  wire logic                  load,
    output sbtp_pkg::char_list_t       list
);

    logic [6:0] pending_bits_reg;
    logic [6:0] pending_bits_next;
    logic [2:0] pending_count_reg;
    logic [2:0] pending_count_next;
    logic       header_sent_reg;
    logic       header_sent_next;

    logic [14:0] acc;
    logic [7:0]  body0;
    logic [7:0]  body1;
    logic [1:0]  body_count;

    always_comb
    begin
        acc                = {8'd0, pending_bits_reg}
                           | ({7'd0, item.data_byte} << pending_count_reg);
        body0              = sbtp_pkg::TERMINATOR;
        body1              = sbtp_pkg::TERMINATOR;
        body_count         = 2'd1;
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        header_sent_next   = header_sent_reg;

        unique case (item.mode)
            sbtp_pkg::MODE_DATA:
            begin
                body0            = sbtp_pkg::MARK_BIT | {1'b0, acc[6:0]};
                header_sent_next = 1'b1;
                if (pending_count_reg == 3'd6)
                begin
                    // Six pending bits plus eight new ones make two whole characters.
                    body1              = sbtp_pkg::MARK_BIT | {1'b0, acc[13:7]};
                    body_count         = 2'd2;
                    pending_bits_next  = 7'd0;
                    pending_count_next = 3'd0;
                end
                else
                begin
                    pending_bits_next  = acc[13:7];
                    pending_count_next = pending_count_reg + 3'd1;
                end
            end
            sbtp_pkg::MODE_END:
            begin
                if (pending_count_reg != 3'd0)
                begin
                    body0      = sbtp_pkg::MARK_BIT | {1'b0, pending_bits_reg};
                    body1      = sbtp_pkg::TERMINATOR;
                    body_count = 2'd2;
                end
                pending_bits_next  = 7'd0;
                pending_count_next = 3'd0;
                header_sent_next   = 1'b0;
            end
            default:
            begin
                body_count = 2'd1;
            end
        endcase

        list.chars = '0;
        if (!header_sent_reg)
        begin
            list.chars[0] = sbtp_pkg::HEADER[0];
            list.chars[1] = sbtp_pkg::HEADER[1];
            list.chars[2] = sbtp_pkg::HEADER[2];
            list.chars[3] = sbtp_pkg::HEADER[3];
            list.chars[4] = body0;
            list.chars[5] = body1;
            list.count    = 3'd4 + {1'b0, body_count};
        end
        else
        begin
            list.chars[0] = body0;
            list.chars[1] = body1;
            list.count    = {1'b0, body_count};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bits_reg  <= 7'd0;
            pending_count_reg <= 3'd0;
            header_sent_reg   <= 1'b0;
        end
        else if (load)
        begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            header_sent_reg   <= header_sent_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sbtp_serial.sv @@
// Result buffer that holds one transaction's character list and hands it out
// one character per cycle while txt_stall is low. Depends on sbtp_pkg.
`default_nettype none

module sbtp_serial (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sbtp_pkg::char_list_t  list,
    input  wire logic                  load,
    output logic                       can_load,
    output logic                       txt_valid,
    input  wire logic                  txt_stall,
    output sbtp_pkg::txt_item_t        txt
);

    logic                                  busy_reg;
    logic [2:0]                            count_reg;
    logic [2:0]                            idx_reg;
    logic [sbtp_pkg::MAX_RESULTS-1:0][7:0] chars_reg;

    logic pop;
    logic at_last;

    assign at_last  = (idx_reg == (count_reg - 3'd1));
    assign pop      = busy_reg && !txt_stall;
    assign can_load = !busy_reg || (pop && at_last);

    assign txt_valid    = busy_reg;
    assign txt.out_char = chars_reg[idx_reg];
    assign txt.run_last = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= 3'd0;
            idx_reg   <= 3'd0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            count_reg <= list.count;
            idx_reg   <= 3'd0;
        end
        else if (pop)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= list.chars;
        end
    end

endmodule

`default_nettype wire

@@ rtl/seven_bit_text_packer.sv @@
// Top level of the seven-bit text packer: input register, packing expansion
// and result buffer. Depends on sbtp_pkg, sbtp_expand and sbtp_serial.
`default_nettype none

// The packer turns a stream of raw message bytes into text-safe characters,
// seven data bits per character with bit 7 always set, filled least
// significant bit first. The first transaction of a message is preceded by
// the header 0x0d 0x0a 0x44 0x42; an end-of-message transaction flushes a
// partial character and then emits a 0 terminator, after which the next
// data byte opens a new message. Each input transaction yields one to five
// output characters, and run_last marks the final one of each group. The
// output side delivers exactly one character per cycle while txt_stall is
// low. A data byte inside a message or the end of an open message yields
// one or two characters; the first byte of a message or an end of message
// while no message is open yields five. That single output character per
// cycle is what sets the sustained rate. A new input transaction is taken
// while the previous one's characters are still being delivered; when the
// output side is free, the first character of a transaction passes through
// the input register and then the result buffer before it is presented on
// the output.
module seven_bit_text_packer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 msg_valid,
    output logic                      msg_stall,
    input  wire sbtp_pkg::msg_item_t  msg,
    output logic                      txt_valid,
    input  wire logic                 txt_stall,
    output sbtp_pkg::txt_item_t       txt
);

    // Input register: holds one accepted transaction until the result
    // buffer can take its character list.
    logic                 in_valid_reg;
    sbtp_pkg::msg_item_t  in_item_reg;

    sbtp_pkg::char_list_t list;
    logic                 can_load;
    logic                 load;

    // The list moves into the result buffer, and the packing state advances,
    // in the same cycle.
    assign load      = in_valid_reg && can_load;
    assign msg_stall = in_valid_reg && !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!msg_stall)
        begin
            in_valid_reg <= msg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_valid && !msg_stall)
        begin
            in_item_reg <= msg;
        end
    end

    sbtp_expand u_expand (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_item_reg),
        .load  (load),
        .list  (list)
    );

    sbtp_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .list      (list),
        .load      (load),
        .can_load  (can_load),
        .txt_valid (txt_valid),
        .txt_stall (txt_stall),
        .txt       (txt)
    );

endmodule

`default_nettype wire
